// File: src/tte_pkg.sv
// ============================================================================
// tte_pkg
// Shared types and codes for the lock-step TFTP transfer engine.
// ============================================================================
`default_nettype none

package tte_pkg;

    // Event codes (func field)
    localparam logic [1:0] FUNC_START_WR = 2'd0;
    localparam logic [1:0] FUNC_START_RD = 2'd1;
    localparam logic [1:0] FUNC_HEADER   = 2'd2;
    localparam logic [1:0] FUNC_CHUNK    = 2'd3;

    // Send kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Transfer phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_RECV    = 2'd1;
    localparam logic [1:0] PH_CHUNK   = 2'd2;
    localparam logic [1:0] PH_ACKWAIT = 2'd3;

    // Packet opcodes
    localparam logic [15:0] OP_DATA = 16'd3;
    localparam logic [15:0] OP_ACK  = 16'd4;

    // Error numbers
    localparam logic [2:0] ERR_UNDEF     = 3'd0;
    localparam logic [2:0] ERR_NOT_FOUND = 3'd1;

    // Datagram sizes
    localparam logic [9:0] HDR_BYTES     = 10'd4;
    localparam logic [9:0] ERR_PKT_BYTES = 10'd5;

    localparam logic [15:0] FIRST_BLOCK = 16'd1;

    // Input transaction
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] pkt_opcode;
        logic [15:0] pkt_block;
        logic [9:0]  pkt_length;
        logic        from_peer;
        logic        sink_ok;
        logic [9:0]  chunk_length;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic [9:0]  send_length;
        logic [2:0]  error_code;
        logic        store_payload;
        logic [9:0]  payload_length;
        logic [1:0]  phase_now;
        logic        done_res;
        logic        aborted;
    } t_result;

    // Classified event between front and back
    typedef struct packed {
        logic [1:0]  func;
        logic        op_data;     // opcode is DATA
        logic        op_ack;      // opcode is ACK
        logic        len_short;   // datagram under header size
        logic        len_fin;     // datagram shorter than a full-block datagram
        logic        pay_nz;      // payload present
        logic [9:0]  pay;         // payload bytes
        logic [15:0] blk;
        logic        peer;
        logic        ok;
        logic [9:0]  data_len;    // outgoing data datagram length
        logic        chunk_short; // chunk below a full block
    } t_evt;

endpackage

`default_nettype wire

// File: src/tftp_transfer_engine_unit.sv
// ============================================================================
// tftp_transfer_engine_unit
// Lock-step TFTP transfer engine: classifier front, event queue,
// sequencer back, result queue.
// ============================================================================
// A push is registered in the event queue, then sequenced into the result
// queue read on o_result. Throughput: one transaction per cycle when no queue
// stalls; the sequencer updates its state once per event and both two-entry
// queues let either side stall alone. Reset (i_rst_n low, synchronous):
// both queues empty, phase idle, expected block 1, short-block flag clear.
`default_nettype none

module tftp_transfer_engine_unit #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire tte_pkg::t_in_item i_item,
    output logic                   empty,
    input  wire logic              pop,
    output tte_pkg::t_result       o_result
);

    tte_pkg::t_evt    evt_in;
    tte_pkg::t_evt    evt_head;
    logic             evt_empty;
    tte_pkg::t_result res;
    logic             res_full;
    logic             fire;

    // Front: classify
    tte_front #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_front (
        .i_item (i_item),
        .o_evt  (evt_in)
    );

    // Event queue between front and back
    tte_fifo #(
        .t_data (tte_pkg::t_evt)
    ) u_evt_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (evt_in),
        .i_rd    (fire),
        .o_rdata (evt_head),
        .o_full  (full),
        .o_empty (evt_empty)
    );

    // Back: sequence one event whenever there is room for its result
    assign fire = !evt_empty && !res_full;

    tte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_evt   (evt_head),
        .o_res   (res)
    );

    // Result queue
    tte_fifo #(
        .t_data (tte_pkg::t_result)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fire),
        .i_wdata (res),
        .i_rd    (pop),
        .o_rdata (o_result),
        .o_full  (res_full),
        .o_empty (empty)
    );

endmodule

`default_nettype wire

// File: src/tte_fifo.sv
// ============================================================================
// tte_fifo
// Two-entry first-word-fall-through queue for any packed type.
// ============================================================================
`default_nettype none

module tte_fifo #(
    parameter type t_data = logic
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr,
    input  wire t_data i_wdata,
    input  wire logic  i_rd,
    output t_data      o_rdata,
    output logic       o_full,
    output logic       o_empty
);

    t_data       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic        wr_en;
    logic        rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wptr <= ~r_wptr;
            end
            if (rd_en) begin
                r_rptr <= ~r_rptr;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/tte_front.sv
// ============================================================================
// tte_front
// Event classifier: clamps lengths and precomputes the compares the
// transfer sequencer needs.
// ============================================================================
`default_nettype none

module tte_front #(
    parameter int BLOCK_BYTES = 512
) (
    input  wire tte_pkg::t_in_item i_item,
    output tte_pkg::t_evt          o_evt
);

    localparam logic [31:0] BLK_LEN  = 32'(BLOCK_BYTES);
    localparam logic [31:0] FULL_LEN = 32'(BLOCK_BYTES + 4);

    logic       plen_ge_full;
    logic       chunk_ge_blk;
    logic [9:0] plen_c;
    logic [9:0] chunk_c;

    // Length clamps; a clamped value never exceeds the raw 10-bit field
    assign plen_ge_full = (32'(i_item.pkt_length) >= FULL_LEN);
    assign chunk_ge_blk = (32'(i_item.chunk_length) >= BLK_LEN);
    assign plen_c  = plen_ge_full ? FULL_LEN[9:0] : i_item.pkt_length;
    assign chunk_c = chunk_ge_blk ? BLK_LEN[9:0] : i_item.chunk_length;

    // Classification
    always_comb begin
        o_evt.func        = i_item.func;
        o_evt.op_data     = (i_item.pkt_opcode == tte_pkg::OP_DATA);
        o_evt.op_ack      = (i_item.pkt_opcode == tte_pkg::OP_ACK);
        o_evt.len_short   = (plen_c < tte_pkg::HDR_BYTES);
        o_evt.len_fin     = !plen_ge_full;
        o_evt.pay         = plen_c - tte_pkg::HDR_BYTES;
        o_evt.pay_nz      = (plen_c > tte_pkg::HDR_BYTES);
        o_evt.blk         = i_item.pkt_block;
        o_evt.peer        = i_item.from_peer;
        o_evt.ok          = i_item.sink_ok;
        o_evt.data_len    = chunk_c + tte_pkg::HDR_BYTES;
        o_evt.chunk_short = !chunk_ge_blk;
    end

endmodule

`default_nettype wire

// File: src/tte_back.sv
// ============================================================================
// tte_back
// Transfer sequencer: holds phase, expected block and short-block flag,
// and builds one result per classified event.
// ============================================================================
`default_nettype none

module tte_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire tte_pkg::t_evt  i_evt,
    output tte_pkg::t_result    o_res
);

    logic [1:0]  r_phase;
    logic [1:0]  n_phase;
    logic [15:0] r_exp;
    logic [15:0] n_exp;
    logic        r_last_short;
    logic        n_last_short;
    logic        op_bad;

    assign op_bad = (r_phase == tte_pkg::PH_RECV) ? !i_evt.op_data : !i_evt.op_ack;

    // Next state and result
    always_comb begin
        n_phase      = r_phase;
        n_exp        = r_exp;
        n_last_short = r_last_short;
        o_res        = '0;
        case (i_evt.func)
            tte_pkg::FUNC_START_WR, tte_pkg::FUNC_START_RD: begin
                if (r_phase == tte_pkg::PH_IDLE) begin
                    if (!i_evt.ok) begin
                        o_res.send_kind   = tte_pkg::KIND_ERR;
                        o_res.send_length = tte_pkg::ERR_PKT_BYTES;
                        o_res.error_code  = tte_pkg::ERR_NOT_FOUND;
                        o_res.aborted     = 1'b1;
                    end else begin
                        n_exp        = tte_pkg::FIRST_BLOCK;
                        n_last_short = 1'b0;
                        if (i_evt.func == tte_pkg::FUNC_START_WR) begin
                            n_phase           = tte_pkg::PH_RECV;
                            o_res.send_kind   = tte_pkg::KIND_ACK;
                            o_res.send_length = tte_pkg::HDR_BYTES;
                        end else begin
                            n_phase = tte_pkg::PH_CHUNK;
                        end
                    end
                end
            end
            tte_pkg::FUNC_CHUNK: begin
                if (r_phase == tte_pkg::PH_CHUNK) begin
                    n_last_short      = i_evt.chunk_short;
                    n_phase           = tte_pkg::PH_ACKWAIT;
                    o_res.send_kind   = tte_pkg::KIND_DATA;
                    o_res.send_block  = r_exp;
                    o_res.send_length = i_evt.data_len;
                end
            end
            tte_pkg::FUNC_HEADER: begin
                if ((r_phase == tte_pkg::PH_RECV || r_phase == tte_pkg::PH_ACKWAIT)
                        && i_evt.peer) begin
                    if (i_evt.len_short || op_bad) begin
                        // malformed peer packet abandons the transfer
                        n_phase       = tte_pkg::PH_IDLE;
                        o_res.aborted = 1'b1;
                    end else if (i_evt.blk == r_exp) begin
                        if (r_phase == tte_pkg::PH_RECV) begin
                            if (i_evt.pay_nz && !i_evt.ok) begin
                                // sink failure
                                n_phase           = tte_pkg::PH_IDLE;
                                o_res.send_kind   = tte_pkg::KIND_ERR;
                                o_res.send_length = tte_pkg::ERR_PKT_BYTES;
                                o_res.error_code  = tte_pkg::ERR_UNDEF;
                                o_res.aborted     = 1'b1;
                            end else begin
                                n_exp                = r_exp + 16'd1;
                                if (i_evt.len_fin) begin
                                    n_phase = tte_pkg::PH_IDLE;
                                end
                                o_res.send_kind      = tte_pkg::KIND_ACK;
                                o_res.send_block     = r_exp;
                                o_res.send_length    = tte_pkg::HDR_BYTES;
                                o_res.store_payload  = i_evt.pay_nz;
                                o_res.payload_length = i_evt.pay;
                                o_res.done_res       = i_evt.len_fin;
                            end
                        end else begin
                            // matching ack on the read side
                            if (r_last_short) begin
                                n_phase        = tte_pkg::PH_IDLE;
                                o_res.done_res = 1'b1;
                            end else begin
                                n_exp   = r_exp + 16'd1;
                                n_phase = tte_pkg::PH_CHUNK;
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        o_res.phase_now = n_phase;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tte_pkg::PH_IDLE;
            r_exp        <= tte_pkg::FIRST_BLOCK;
            r_last_short <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_exp        <= n_exp;
            r_last_short <= n_last_short;
        end
    end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the lock-step TFTP transfer engine. A behavioral
// predictor follows phase, block number and short-block flag for every
// accepted event. Each popped result is compared field by field against the
// oldest prediction. Directed write, read and abort scenarios run first,
// then a fill-up burst, then mostly well-formed random transfers with noise.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          BLOCK_BYTES = 512;
    localparam logic [9:0]  FULL_DGRAM  = 10'(BLOCK_BYTES) + tte_pkg::HDR_BYTES;
    localparam int          QUIET_LIMIT = 1000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push    = 1'b0;
    logic              pop     = 1'b0;
    tte_pkg::t_in_item i_item  = '0;
    logic              full;
    logic              empty;
    tte_pkg::t_result  o_result;

    // Predictor state
    logic [1:0]  cur_phase   = tte_pkg::PH_IDLE;
    logic [15:0] want_block  = tte_pkg::FIRST_BLOCK;
    logic        sent_short  = 1'b0;

    tte_pkg::t_result pending_responses[$];

    int n_in      = 0;
    int n_out     = 0;
    int n_errors  = 0;
    int n_done    = 0;
    int n_abort   = 0;
    int quiet     = 0;
    int hold_req  = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    tftp_transfer_engine_unit #(.BLOCK_BYTES(BLOCK_BYTES)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: ends the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("tftp_transfer_engine_unit: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // Engine behavior for one event; updates the predictor state
    function automatic tte_pkg::t_result next_response(input tte_pkg::t_in_item it);
        tte_pkg::t_result r;
        logic [9:0]       dlen;
        logic [9:0]       clen;
        logic [9:0]       pay;
        logic [15:0]      want_op;
        r = '0;
        case (it.func)
            tte_pkg::FUNC_START_WR, tte_pkg::FUNC_START_RD: begin
                if (cur_phase == tte_pkg::PH_IDLE) begin
                    if (!it.sink_ok) begin
                        r.send_kind   = tte_pkg::KIND_ERR;
                        r.send_length = tte_pkg::ERR_PKT_BYTES;
                        r.error_code  = tte_pkg::ERR_NOT_FOUND;
                        r.aborted     = 1'b1;
                    end else begin
                        want_block = tte_pkg::FIRST_BLOCK;
                        sent_short = 1'b0;
                        if (it.func == tte_pkg::FUNC_START_WR) begin
                            cur_phase     = tte_pkg::PH_RECV;
                            r.send_kind   = tte_pkg::KIND_ACK;
                            r.send_length = tte_pkg::HDR_BYTES;
                        end else begin
                            cur_phase = tte_pkg::PH_CHUNK;
                        end
                    end
                end
            end
            tte_pkg::FUNC_CHUNK: begin
                if (cur_phase == tte_pkg::PH_CHUNK) begin
                    clen = (it.chunk_length > BLOCK_BYTES) ? 10'(BLOCK_BYTES)
                                                           : it.chunk_length;
                    sent_short    = (clen < BLOCK_BYTES);
                    cur_phase     = tte_pkg::PH_ACKWAIT;
                    r.send_kind   = tte_pkg::KIND_DATA;
                    r.send_block  = want_block;
                    r.send_length = clen + tte_pkg::HDR_BYTES;
                end
            end
            default: begin
                // received header: only the peer counts, and only mid-transfer
                if ((cur_phase == tte_pkg::PH_RECV || cur_phase == tte_pkg::PH_ACKWAIT)
                        && it.from_peer) begin
                    dlen    = (it.pkt_length > FULL_DGRAM) ? FULL_DGRAM : it.pkt_length;
                    want_op = (cur_phase == tte_pkg::PH_RECV) ? tte_pkg::OP_DATA
                                                              : tte_pkg::OP_ACK;
                    if (dlen < tte_pkg::HDR_BYTES || it.pkt_opcode != want_op) begin
                        cur_phase = tte_pkg::PH_IDLE;
                        r.aborted = 1'b1;
                    end else if (it.pkt_block == want_block) begin
                        if (cur_phase == tte_pkg::PH_RECV) begin
                            pay = dlen - tte_pkg::HDR_BYTES;
                            if (pay != 0 && !it.sink_ok) begin
                                cur_phase     = tte_pkg::PH_IDLE;
                                r.send_kind   = tte_pkg::KIND_ERR;
                                r.send_length = tte_pkg::ERR_PKT_BYTES;
                                r.error_code  = tte_pkg::ERR_UNDEF;
                                r.aborted     = 1'b1;
                            end else begin
                                r.send_kind      = tte_pkg::KIND_ACK;
                                r.send_block     = want_block;
                                r.send_length    = tte_pkg::HDR_BYTES;
                                r.store_payload  = (pay != 0);
                                r.payload_length = pay;
                                want_block       = want_block + 16'd1;
                                if (dlen < FULL_DGRAM) begin
                                    cur_phase  = tte_pkg::PH_IDLE;
                                    r.done_res = 1'b1;
                                end
                            end
                        end else if (sent_short) begin
                            cur_phase  = tte_pkg::PH_IDLE;
                            r.done_res = 1'b1;
                        end else begin
                            want_block = want_block + 16'd1;
                            cur_phase  = tte_pkg::PH_CHUNK;
                        end
                    end
                end
            end
        endcase
        r.phase_now = cur_phase;
        return r;
    endfunction

    function automatic tte_pkg::t_in_item mk(input logic [1:0] func,
                                             input logic [15:0] opc,
                                             input logic [15:0] blk,
                                             input logic [9:0] plen,
                                             input logic peer, input logic ok,
                                             input logic [9:0] chunk);
        tte_pkg::t_in_item it;
        it.func         = func;
        it.pkt_opcode   = opc;
        it.pkt_block    = blk;
        it.pkt_length   = plen;
        it.from_peer    = peer;
        it.sink_ok      = ok;
        it.chunk_length = chunk;
        return it;
    endfunction

    // Next event of a plausible transfer, with some pure noise mixed in
    function automatic tte_pkg::t_in_item gen_item();
        tte_pkg::t_in_item it;
        logic [63:0]       raw;
        int                pick;
        raw  = {$urandom, $urandom};
        it   = raw[$bits(tte_pkg::t_in_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 12) return it;
        it.from_peer = ($urandom_range(0, 19) != 0);
        it.sink_ok   = ($urandom_range(0, 19) != 0);
        case (cur_phase)
            tte_pkg::PH_IDLE: begin
                it.func = $urandom_range(0, 1) ? tte_pkg::FUNC_START_WR
                                               : tte_pkg::FUNC_START_RD;
            end
            tte_pkg::PH_RECV: begin
                it.func       = tte_pkg::FUNC_HEADER;
                it.pkt_opcode = ($urandom_range(0, 19) != 0) ? tte_pkg::OP_DATA
                                                             : it.pkt_opcode;
                it.pkt_block  = ($urandom_range(0, 9) != 0) ? want_block
                                                            : want_block - 16'd1;
                it.pkt_length = ($urandom_range(0, 4) != 0) ? FULL_DGRAM
                                                            : 10'($urandom_range(0, 1023));
            end
            tte_pkg::PH_CHUNK: begin
                it.func         = tte_pkg::FUNC_CHUNK;
                it.chunk_length = ($urandom_range(0, 3) != 0) ? 10'(BLOCK_BYTES)
                                                              : 10'($urandom_range(0, 1023));
            end
            default: begin
                it.func       = tte_pkg::FUNC_HEADER;
                it.pkt_opcode = ($urandom_range(0, 19) != 0) ? tte_pkg::OP_ACK
                                                             : it.pkt_opcode;
                it.pkt_block  = ($urandom_range(0, 9) != 0) ? want_block
                                                            : 16'($urandom);
                it.pkt_length = ($urandom_range(0, 2) != 0) ? tte_pkg::HDR_BYTES
                                                            : 10'($urandom_range(4, 1023));
            end
        endcase
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        n_errors++;
        $display("%0t ns: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Offer one transaction, predict its response once accepted
    task automatic send_item(input tte_pkg::t_in_item it);
        int               gap;
        tte_pkg::t_result r;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        r = next_response(it);
        pending_responses.push_back(r);
        n_in++;
        if (r.done_res) n_done++;
        if (r.aborted)  n_abort++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_responses.size() != 0);
    endtask

    task automatic check_result(input tte_pkg::t_result got);
        tte_pkg::t_result want;
        n_out++;
        if (pending_responses.size() == 0) begin
            report_mismatch("result with none pending, send_kind",
                            32'(got.send_kind), 0);
            return;
        end
        want = pending_responses.pop_front();
        if (got.send_kind != want.send_kind)
            report_mismatch("send_kind", 32'(got.send_kind), 32'(want.send_kind));
        if (got.send_block != want.send_block)
            report_mismatch("send_block", 32'(got.send_block), 32'(want.send_block));
        if (got.send_length != want.send_length)
            report_mismatch("send_length", 32'(got.send_length), 32'(want.send_length));
        if (got.error_code != want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
        if (got.store_payload != want.store_payload)
            report_mismatch("store_payload", 32'(got.store_payload),
                            32'(want.store_payload));
        if (got.payload_length != want.payload_length)
            report_mismatch("payload_length", 32'(got.payload_length),
                            32'(want.payload_length));
        if (got.phase_now != want.phase_now)
            report_mismatch("phase_now", 32'(got.phase_now), 32'(want.phase_now));
        if (got.done_res != want.done_res)
            report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
        if (got.aborted != want.aborted)
            report_mismatch("aborted", 32'(got.aborted), 32'(want.aborted));
    endtask

    // Result side: random pop stalls, one long hold on request
    initial begin : result_drain
        int wait_n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                wait_n   = hold_req;
                hold_req = 0;
            end else begin
                wait_n = rx_steady ? 0 : $urandom_range(0, 3);
            end
            if (wait_n > 0) begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            check_result(o_result);
        end
    end

    // Write transfer: ack 0, in-order blocks, clamped length, short final block
    task automatic test_write_transfer();
        send_item(mk(tte_pkg::FUNC_START_WR, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_START_RD, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd1, 10'd516,
                     1'b0, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd1, 10'd516,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'hFFFF, 10'd516,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd2, 10'd1023,
                     1'b1, 1'b1, 10'd1023));
        send_item(mk(tte_pkg::FUNC_CHUNK, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd100));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd3, 10'd4,
                     1'b1, 1'b0, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd4, 10'd516,
                     1'b1, 1'b1, 10'd0));
    endtask

    // Read transfer: open failure, clamped chunk, stale ack, ack of short block
    task automatic test_read_transfer();
        send_item(mk(tte_pkg::FUNC_START_RD, 16'd0, 16'd0, 10'd0, 1'b1, 1'b0, 10'd0));
        send_item(mk(tte_pkg::FUNC_START_RD, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_ACK, 16'd1, 10'd4,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_CHUNK, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd1023));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_ACK, 16'd0, 10'd4,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_ACK, 16'd1, 10'd4,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_CHUNK, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_ACK, 16'd2, 10'd1023,
                     1'b1, 1'b1, 10'd0));
    endtask

    // Abort paths: runt datagram, wrong opcode, store failure, open failure
    task automatic test_aborts();
        send_item(mk(tte_pkg::FUNC_START_WR, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd1, 10'd0,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_START_WR, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_ACK, 16'd1, 10'd516,
                     1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_START_WR, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_HEADER, tte_pkg::OP_DATA, 16'd1, 10'd100,
                     1'b1, 1'b0, 10'd0));
        send_item(mk(tte_pkg::FUNC_START_RD, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_CHUNK, 16'd0, 16'd0, 10'd0, 1'b1, 1'b1, 10'd511));
        send_item(mk(tte_pkg::FUNC_HEADER, 16'hFFFF, 16'd1, 10'd4, 1'b1, 1'b1, 10'd0));
        send_item(mk(tte_pkg::FUNC_START_WR, 16'd0, 16'd0, 10'd0, 1'b1, 1'b0, 10'd0));
    endtask

    // Result side holds off while the sender keeps pushing; queues fill up
    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_req  = 60;
        repeat (24) send_item(gen_item());
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                rx_steady = ($urandom_range(0, 3) == 0);
            end
            send_item(gen_item());
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_write_transfer();
        test_read_transfer();
        test_aborts();
        test_backpressure();
        test_random_traffic(400);
        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d events through write, read, abort and back-pressure cases",
                 n_in);
        $display("Checked %0d results: %0d transfers finished, %0d abandoned",
                 n_out, n_done, n_abort);
        if (n_errors == 0) begin
            $display("tftp_transfer_engine_unit: match");
        end else begin
            $display("tftp_transfer_engine_unit: mismatch");
        end
        $finish;
    end

endmodule
